### src/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
`timescale 1ns / 1ps

package mcr_pkg;

  // Input item kinds, carried on in_tuser
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_t;

  localparam int CENTER_W  = 15;
  localparam int RAD_IN_W  = 12;
  localparam int COLOR_W   = 32;
  localparam int DEC_BITS  = 16;
  localparam int IN_DATA_W = 80;

  // Results per step: eight points in outline mode, four spans when filled
  localparam int MAX_RES = 8;
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam logic [IDX_W-1:0] LAST_POINT = IDX_W'(MAX_RES - 1);
  localparam logic [IDX_W-1:0] LAST_SPAN  = IDX_W'(MAX_RES / 2 - 1);

  // Command queue between the front and the back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Input payload as packed on in_tdata, last field lowest
  typedef struct packed {
    logic [COLOR_W-1:0]         color;
    logic                       filled;
    logic [RAD_IN_W-1:0]        radius;
    logic signed [CENTER_W-1:0] center_y;
    logic signed [CENTER_W-1:0] center_x;
  } in_item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic head_valid;
  } q_stat_t;

endpackage

### src/mcr_queue.sv
// Two-entry command queue between the decision front end and the emit back end.
`timescale 1ns / 1ps

module mcr_queue #(
  parameter int W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [W-1:0]     push_data,
  input  logic             pop,
  output logic [W-1:0]     head_data,
  output mcr_pkg::q_stat_t stat
);
  import mcr_pkg::*;

  logic [W-1:0]       mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign stat.full       = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat.head_valid = (count_r != '0);
  assign head_data       = mem_r[rd_ptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

### src/mcr_front.sv
// Front end: takes start and step transactions, runs the midpoint decision rule.
`timescale 1ns / 1ps

module mcr_front #(
  parameter  int RADIUS_BITS = 12,
  parameter  int COORD_BITS  = 16,
  localparam int CMD_W       = 4 * COORD_BITS + mcr_pkg::COLOR_W + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mcr_pkg::req_kind_t in_kind,
  input  mcr_pkg::in_item_t in_item,
  input  mcr_pkg::q_stat_t  q_stat,
  output logic              push,
  output logic [CMD_W-1:0]  push_cmd
);
  import mcr_pkg::*;

  localparam int OFF_BITS = RADIUS_BITS + 1;
  localparam int MAXW     = (DEC_BITS > OFF_BITS) ? DEC_BITS : OFF_BITS;
  localparam int CW       = MAXW + 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] ox;
    logic signed [COORD_BITS-1:0] oy;
    logic [COLOR_W-1:0]           color;
    logic                         fill;
    logic                         done;
  } cmd_t;

  logic                         busy_r, fill_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [RADIUS_BITS-1:0]       rad_r;
  logic signed [OFF_BITS-1:0]   ox_r, oy_r;
  logic signed [DEC_BITS-1:0]   dec_r;
  logic [COLOR_W-1:0]           color_r;

  logic                          accept;
  logic [RADIUS_BITS+RAD_IN_W-1:0] rad_ext;
  logic [RADIUS_BITS-1:0]        rad_in;
  logic [CW-1:0]                 rad_in_w;
  logic [CW-1:0]                 dec_start_w;
  logic [COORD_BITS+CENTER_W-1:0] cx_ext, cy_ext;
  logic signed [CW-1:0]          d_w, ox_w, oy_w, r_w, lim_w, d_nxt;
  logic signed [CW-1:0]          ox_nxt_w, oy_nxt_w;
  logic signed [OFF_BITS-1:0]    ox_nxt, oy_nxt;
  logic                          done_nxt;
  logic [COORD_BITS+OFF_BITS-1:0] ox_c, oy_c;
  cmd_t                          cmd;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Start values: radius fitted to RADIUS_BITS, centre fitted to COORD_BITS
  assign rad_ext     = {{RADIUS_BITS{1'b0}}, in_item.radius};
  assign rad_in      = rad_ext[RADIUS_BITS-1:0];
  assign rad_in_w    = {{(CW-RADIUS_BITS){1'b0}}, rad_in};
  assign dec_start_w = rad_in_w - 1'b1;
  assign cx_ext      = {{COORD_BITS{in_item.center_x[CENTER_W-1]}}, in_item.center_x};
  assign cy_ext      = {{COORD_BITS{in_item.center_y[CENTER_W-1]}}, in_item.center_y};

  // One iteration of the decision rule, done at full precision then wrapped
  assign d_w   = {{(CW-DEC_BITS){dec_r[DEC_BITS-1]}}, dec_r};
  assign ox_w  = {{(CW-OFF_BITS){ox_r[OFF_BITS-1]}}, ox_r};
  assign oy_w  = {{(CW-OFF_BITS){oy_r[OFF_BITS-1]}}, oy_r};
  assign r_w   = {{(CW-RADIUS_BITS){1'b0}}, rad_r};
  assign lim_w = (r_w - oy_w) <<< 1;

  always_comb begin
    if (d_w >= (ox_w <<< 1)) begin
      d_nxt    = d_w - (ox_w <<< 1) - CW'(1);
      ox_nxt_w = ox_w + CW'(1);
      oy_nxt_w = oy_w;
    end else if (d_w < lim_w) begin
      d_nxt    = d_w + (oy_w <<< 1) - CW'(1);
      ox_nxt_w = ox_w;
      oy_nxt_w = oy_w - CW'(1);
    end else begin
      d_nxt    = d_w + ((oy_w - ox_w - CW'(1)) <<< 1);
      ox_nxt_w = ox_w + CW'(1);
      oy_nxt_w = oy_w - CW'(1);
    end
  end

  assign ox_nxt   = ox_nxt_w[OFF_BITS-1:0];
  assign oy_nxt   = oy_nxt_w[OFF_BITS-1:0];
  assign done_nxt = (oy_nxt < ox_nxt);

  // Command for the back end: current offsets fitted to coordinate width
  assign ox_c       = {{COORD_BITS{ox_r[OFF_BITS-1]}}, ox_r};
  assign oy_c       = {{COORD_BITS{oy_r[OFF_BITS-1]}}, oy_r};
  assign cmd.cx     = cx_r;
  assign cmd.cy     = cy_r;
  assign cmd.ox     = ox_c[COORD_BITS-1:0];
  assign cmd.oy     = oy_c[COORD_BITS-1:0];
  assign cmd.color  = color_r;
  assign cmd.fill   = fill_r;
  assign cmd.done   = done_nxt;
  assign push_cmd   = cmd;
  assign push       = accept && (in_kind == REQ_STEP) && busy_r;

  // Circle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fill_r  <= 1'b0;
      cx_r    <= '0;
      cy_r    <= '0;
      rad_r   <= '0;
      ox_r    <= '0;
      oy_r    <= '0;
      dec_r   <= '0;
      color_r <= '0;
    end else if (accept) begin
      if (in_kind == REQ_START) begin
        busy_r  <= 1'b1;
        fill_r  <= in_item.filled;
        cx_r    <= cx_ext[COORD_BITS-1:0];
        cy_r    <= cy_ext[COORD_BITS-1:0];
        rad_r   <= rad_in;
        ox_r    <= '0;
        oy_r    <= {1'b0, rad_in};
        dec_r   <= dec_start_w[DEC_BITS-1:0];
        color_r <= in_item.color;
      end else if (busy_r) begin
        ox_r  <= ox_nxt;
        oy_r  <= oy_nxt;
        dec_r <= d_nxt[DEC_BITS-1:0];
        if (done_nxt) busy_r <= 1'b0;
      end
    end
  end

endmodule

### src/mcr_back.sv
// Back end: expands a queued step into points or spans, one per cycle unless held.
`timescale 1ns / 1ps

module mcr_back #(
  parameter  int COORD_BITS = 16,
  localparam int CMD_W      = 4 * COORD_BITS + mcr_pkg::COLOR_W + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcr_pkg::q_stat_t              q_stat,
  input  logic [CMD_W-1:0]              head_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS-1:0]  out_x_start,
  output logic signed [COORD_BITS-1:0]  out_x_end,
  output logic signed [COORD_BITS-1:0]  out_y_pos,
  output logic [mcr_pkg::COLOR_W-1:0]   out_color,
  output logic                          out_last,
  output logic                          out_done
);
  import mcr_pkg::*;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] ox;
    logic signed [COORD_BITS-1:0] oy;
    logic [COLOR_W-1:0]           color;
    logic                         fill;
    logic                         done;
  } cmd_t;

  cmd_t                         cmd;
  logic [IDX_W-1:0]             idx_r;
  logic                         valid_r;
  logic signed [COORD_BITS-1:0] xs_r, xe_r, y_r;
  logic [COLOR_W-1:0]           color_r;
  logic                         last_r, done_r;

  logic                         load, emit, last;
  logic                         outer;
  logic signed [COORD_BITS-1:0] xoff, yoff, xs, xe, y;

  assign cmd  = head_cmd;
  assign load = !valid_r || out_ready;
  assign emit = load && q_stat.head_valid;
  assign last = (idx_r == (cmd.fill ? LAST_SPAN : LAST_POINT));
  assign pop  = emit && last;

  // Point order: bit 0 swaps the offsets, bit 1 negates x, bit 2 negates y.
  // Span order: first and last rows use the swapped offsets, rows 2 and 3 lie above.
  assign outer = (idx_r == IDX_W'(0)) || (idx_r == LAST_SPAN);

  always_comb begin
    if (cmd.fill) begin
      xoff = outer ? cmd.oy : cmd.ox;
      yoff = outer ? cmd.ox : cmd.oy;
      xs   = cmd.cx - xoff;
      xe   = cmd.cx + xoff;
      y    = idx_r[1] ? (cmd.cy - yoff) : (cmd.cy + yoff);
    end else begin
      xoff = idx_r[0] ? cmd.oy : cmd.ox;
      yoff = idx_r[0] ? cmd.ox : cmd.oy;
      xs   = idx_r[1] ? (cmd.cx - xoff) : (cmd.cx + xoff);
      xe   = xs;
      y    = idx_r[2] ? (cmd.cy - yoff) : (cmd.cy + yoff);
    end
  end

  // Output register and result counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (emit) begin
      valid_r <= 1'b1;
      idx_r   <= last ? '0 : idx_r + 1'b1;
    end else if (load) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      xs_r    <= xs;
      xe_r    <= xe;
      y_r     <= y;
      color_r <= cmd.color;
      last_r  <= last;
      done_r  <= cmd.done;
    end
  end

  assign out_valid   = valid_r;
  assign out_x_start = xs_r;
  assign out_x_end   = xe_r;
  assign out_y_pos   = y_r;
  assign out_color   = color_r;
  assign out_last    = last_r;
  assign out_done    = done_r;

endmodule

### src/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: front end, command queue, back end.
//
//  channel | direction | tdata                                   | tuser       | tlast
//  in_     | slave     | center_x, center_y, radius, filled, color | req_type  | -
//  out_    | master    | x_start, x_end, y_pos, pixel_color      | circle_done | last_in_step
//
// A start transaction updates the circle registers and yields nothing.
// A step transaction is taken while the two-entry queue has room; the back end then
// expands it into eight points (outline) or four spans (filled), one result a cycle
// on the single result port while out_tready allows.
// A stalled out_tready holds the output register; steps keep queueing until the queue fills.
// rst_n is synchronous and clears all circle and handshake state.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer #(
  parameter  int RADIUS_BITS = 12,
  parameter  int COORD_BITS  = 16,
  localparam int OUT_DATA_W  = ((3 * COORD_BITS + mcr_pkg::COLOR_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // center_x[14:0], center_y[29:15], radius[41:30], filled[42], color[74:43], zeros above
  input  logic [mcr_pkg::IN_DATA_W-1:0] in_tdata,
  // req_type
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // x_start, x_end, y_pos (COORD_BITS each), pixel_color, zeros above
  output logic [OUT_DATA_W-1:0]         out_tdata,
  // circle_done
  output logic [0:0]                    out_tuser,
  output logic                          out_tlast
);
  import mcr_pkg::*;

  localparam int CMD_W = 4 * COORD_BITS + COLOR_W + 2;

  in_item_t                     item;
  req_kind_t                    kind;
  q_stat_t                      q_stat;
  logic                         q_push, q_pop;
  logic [CMD_W-1:0]             push_cmd, head_cmd;
  logic signed [COORD_BITS-1:0] x_start, x_end, y_pos;
  logic [COLOR_W-1:0]           pixel_color;
  logic                         last_in_step, circle_done;

  assign item = in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
  assign kind = req_kind_t'(in_tuser[0]);

  mcr_front #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (kind),
    .in_item  (item),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_cmd (push_cmd)
  );

  mcr_queue #(
    .W (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .head_data (head_cmd),
    .stat      (q_stat)
  );

  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .head_cmd    (head_cmd),
    .pop         (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_x_start (x_start),
    .out_x_end   (x_end),
    .out_y_pos   (y_pos),
    .out_color   (pixel_color),
    .out_last    (last_in_step),
    .out_done    (circle_done)
  );

  assign out_tdata = OUT_DATA_W'({pixel_color, y_pos, x_end, x_start});
  assign out_tuser = circle_done;
  assign out_tlast = last_in_step;

  // The front never writes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_stat.full))
    else $error("command written into a full queue");

  // The back only retires a command that is present
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_stat.head_valid)
    else $error("queue popped while empty");

  // Reset leaves the queue empty and the output register idle
  assert property (@(posedge clk) !rst_n |=> (!q_stat.head_valid && !out_tvalid))
    else $error("queue or output not cleared by reset");

endmodule
